### hw/rtl/float_dot_product_double_accum_unit_macros.svh
// Assertion macros shared by the dot product unit.
`ifndef FLOAT_DOT_PRODUCT_DOUBLE_ACCUM_UNIT_MACROS_SVH
`define FLOAT_DOT_PRODUCT_DOUBLE_ACCUM_UNIT_MACROS_SVH

// Flag a condition that must never hold while out of reset.
`define FDPA_ASSERT_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

// Flag a consequence that must hold in the cycle after its antecedent.
`define FDPA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/fdpa_pkg.sv
// Shared types and constants of the dot product unit.
`default_nettype none

package fdpa_pkg;

    localparam int QUEUE_DEPTH = 4;

    localparam logic [63:0] CANON_QNAN = 64'h7FF8_0000_0000_0000;
    localparam logic [10:0] F64_EXP_ONES = 11'h7FF;

    // One exact product, already packed as binary64, with its end-of-vector mark.
    typedef struct packed {
        logic [63:0] bits;
        logic        last;
    } prod_t;

endpackage

`default_nettype wire

### hw/rtl/fdpa_front.sv
// Front end: accept pairs, classify, multiply exactly, pack as binary64.
`default_nettype none

module fdpa_front #(
    parameter int QDEPTH = fdpa_pkg::QUEUE_DEPTH
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic [31:0]                    a_bits,
    input  logic [31:0]                    b_bits,
    input  logic                           last_pair,
    input  logic                           push,
    output logic                           full,
    input  logic [$clog2(QDEPTH+1)-1:0]    q_count,
    output logic                           q_push,
    output fdpa_pkg::prod_t                q_data
);

    localparam int CW = $clog2(QDEPTH + 1);

    typedef enum logic [1:0] {PC_FIN, PC_ZERO, PC_INF, PC_NAN} pcls_t;

    function automatic logic [4:0] lz24(input logic [23:0] m);
        logic [4:0] n;
        n = 5'd0;
        for (int i = 0; i < 24; i++)
        begin
            if (m[i])
            begin
                n = 5'(23 - i);
            end
        end
        return n;
    endfunction

    logic        accept;
    logic [7:0]  ea, eb;
    logic [22:0] fa, fb;
    logic        a_nan, a_inf, a_zero, b_nan, b_inf, b_zero;
    logic [23:0] ma, mb;
    logic [4:0]  lza, lzb;
    pcls_t       cls_next;

    logic                  v1_reg;
    pcls_t                 cls_reg;
    logic                  sign_reg;
    logic                  last1_reg;
    logic signed [9:0]     ea_reg, eb_reg;
    logic [23:0]           ma_reg, mb_reg;

    logic [47:0]           prod;
    logic signed [10:0]    esum;
    logic signed [11:0]    ex12;
    logic [51:0]           frac;
    logic [63:0]           bits_next;

    logic                  v2_reg;
    fdpa_pkg::prod_t       out_reg;

    // Hold back while queued plus in-flight products could overrun the queue.
    assign full   = ({1'b0, q_count} + (CW+1)'(v1_reg) + (CW+1)'(v2_reg)) >= (CW+1)'(QDEPTH);
    assign accept = push && !full;

    assign ea = a_bits[30:23];
    assign eb = b_bits[30:23];
    assign fa = a_bits[22:0];
    assign fb = b_bits[22:0];
    assign a_nan  = (&ea) && (|fa);
    assign a_inf  = (&ea) && !(|fa);
    assign a_zero = (ea == 8'd0) && (fa == 23'd0);
    assign b_nan  = (&eb) && (|fb);
    assign b_inf  = (&eb) && !(|fb);
    assign b_zero = (eb == 8'd0) && (fb == 23'd0);
    assign ma  = {|ea, fa};
    assign mb  = {|eb, fb};
    assign lza = lz24(ma);
    assign lzb = lz24(mb);

    always_comb
    begin
        if (a_nan || b_nan || (a_inf && b_zero) || (a_zero && b_inf))
        begin
            cls_next = PC_NAN;
        end
        else if (a_inf || b_inf)
        begin
            cls_next = PC_INF;
        end
        else if (a_zero || b_zero)
        begin
            cls_next = PC_ZERO;
        end
        else
        begin
            cls_next = PC_FIN;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= accept;
            v2_reg <= v1_reg;
        end
    end

    // Normalize subnormal significands so the product needs one bit of adjust.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cls_reg   <= cls_next;
            sign_reg  <= a_bits[31] ^ b_bits[31];
            last1_reg <= last_pair;
            ma_reg    <= ma << lza;
            mb_reg    <= mb << lzb;
            ea_reg    <= $signed({2'b00, (ea == 8'd0) ? 8'd1 : ea}) - $signed({5'd0, lza});
            eb_reg    <= $signed({2'b00, (eb == 8'd0) ? 8'd1 : eb}) - $signed({5'd0, lzb});
        end
    end

    assign prod = ma_reg * mb_reg;
    assign esum = 11'(ea_reg) + 11'(eb_reg);
    assign ex12 = 12'(esum) + (prod[47] ? 12'sd770 : 12'sd769);
    assign frac = prod[47] ? {prod[46:0], 5'd0} : {prod[45:0], 6'd0};

    always_comb
    begin
        case (cls_reg)
            PC_FIN:  bits_next = {sign_reg, ex12[10:0], frac};
            PC_ZERO: bits_next = {sign_reg, 63'd0};
            PC_INF:  bits_next = {sign_reg, fdpa_pkg::F64_EXP_ONES, 52'd0};
            default: bits_next = fdpa_pkg::CANON_QNAN;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (v1_reg)
        begin
            out_reg.bits <= bits_next;
            out_reg.last <= last1_reg;
        end
    end

    assign q_push = v2_reg;
    assign q_data = out_reg;

endmodule

`default_nettype wire

### hw/rtl/fdpa_queue.sv
// Short product queue between front end and accumulator.
`default_nettype none

module fdpa_queue #(
    parameter int QDEPTH = fdpa_pkg::QUEUE_DEPTH
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        push,
    input  fdpa_pkg::prod_t             din,
    input  logic                        pop,
    output fdpa_pkg::prod_t             dout,
    output logic                        empty,
    output logic [$clog2(QDEPTH+1)-1:0] count
);

    localparam int AW = $clog2(QDEPTH);
    localparam int CW = $clog2(QDEPTH + 1);

    fdpa_pkg::prod_t mem_reg [QDEPTH];
    logic [AW-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0]   count_reg, count_next;
    logic            do_pop;

    assign do_pop = pop && (count_reg != '0);

    always_comb
    begin
        count_next = count_reg;
        if (push && !do_pop)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (do_pop && !push)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == AW'(QDEPTH - 1)) ? '0 : wr_ptr_reg + AW'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == AW'(QDEPTH - 1)) ? '0 : rd_ptr_reg + AW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= din;
        end
    end

    assign dout  = mem_reg[rd_ptr_reg];
    assign empty = (count_reg == '0);
    assign count = count_reg;

endmodule

`default_nettype wire

### hw/rtl/fdpa_back.sv
// Back end: four-step binary64 add into the running sum, result register.
`default_nettype none

module fdpa_back (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             q_empty,
    input  fdpa_pkg::prod_t  q_head,
    output logic             q_pop,
    input  logic             pop,
    output logic             empty,
    output logic [63:0]      sum_bits
);

    typedef enum logic [1:0] {ST_ALIGN, ST_ADD, ST_NORM, ST_ROUND} state_t;

    function automatic logic [5:0] lz56(input logic [55:0] m);
        logic [5:0] n;
        n = 6'd0;
        for (int i = 0; i < 56; i++)
        begin
            if (m[i])
            begin
                n = 6'(55 - i);
            end
        end
        return n;
    endfunction

    state_t        state_reg;
    logic [63:0]   acc_reg;
    logic          out_valid_reg;
    logic [63:0]   out_bits_reg;

    logic          spec_reg, last_reg, sub_reg, sign_reg, zero_reg;
    logic [63:0]   spec_bits_reg;
    logic [55:0]   ml_reg, ms_reg;
    logic [10:0]   ex_reg;
    logic [56:0]   sum_reg;
    logic [5:0]    lz_reg;

    logic [63:0]   h;
    logic          start;
    logic          a_nan, a_inf, a_zero, h_nan, h_inf, h_zero;
    logic          spec_next;
    logic [63:0]   spec_bits_next;
    logic          big_is_acc;
    logic [63:0]   big, sml;
    logic [10:0]   e_big, e_sml, d;
    logic [5:0]    dsh;
    logic [55:0]   m_big, m_sml, sml_sh;
    logic [111:0]  wide;
    logic [5:0]    lz_all;
    logic [10:0]   ex_m1;

    logic [55:0]        nrm;
    logic signed [12:0] exn, exr;
    logic               rnd;
    logic [53:0]        m54;
    logic [63:0]        rounded, res;

    assign h     = q_head.bits;
    assign start = (state_reg == ST_ALIGN) && !q_empty && !(q_head.last && out_valid_reg);
    assign q_pop = start;

    assign a_nan  = (acc_reg[62:52] == fdpa_pkg::F64_EXP_ONES) && (|acc_reg[51:0]);
    assign a_inf  = (acc_reg[62:52] == fdpa_pkg::F64_EXP_ONES) && !(|acc_reg[51:0]);
    assign a_zero = (acc_reg[62:0] == 63'd0);
    assign h_nan  = (h[62:52] == fdpa_pkg::F64_EXP_ONES) && (|h[51:0]);
    assign h_inf  = (h[62:52] == fdpa_pkg::F64_EXP_ONES) && !(|h[51:0]);
    assign h_zero = (h[62:0] == 63'd0);

    always_comb
    begin
        spec_next      = 1'b1;
        spec_bits_next = acc_reg;
        if (a_nan || h_nan || (a_inf && h_inf && (acc_reg[63] != h[63])))
        begin
            spec_bits_next = fdpa_pkg::CANON_QNAN;
        end
        else if (a_inf)
        begin
            spec_bits_next = acc_reg;
        end
        else if (h_inf)
        begin
            spec_bits_next = h;
        end
        else if (a_zero && h_zero)
        begin
            spec_bits_next = {acc_reg[63] & h[63], 63'd0};
        end
        else if (a_zero)
        begin
            spec_bits_next = h;
        end
        else if (h_zero)
        begin
            spec_bits_next = acc_reg;
        end
        else
        begin
            spec_next = 1'b0;
        end
    end

    // Align the smaller magnitude under the larger, jamming lost bits into sticky.
    assign big_is_acc = acc_reg[62:0] >= h[62:0];
    assign big   = big_is_acc ? acc_reg : h;
    assign sml   = big_is_acc ? h : acc_reg;
    assign e_big = (big[62:52] == 11'd0) ? 11'd1 : big[62:52];
    assign e_sml = (sml[62:52] == 11'd0) ? 11'd1 : sml[62:52];
    assign d     = e_big - e_sml;
    assign dsh   = (d > 11'd56) ? 6'd56 : d[5:0];
    assign m_big = {|big[62:52], big[51:0], 3'b000};
    assign m_sml = {|sml[62:52], sml[51:0], 3'b000};
    assign wide  = {m_sml, 56'd0} >> dsh;
    assign sml_sh = wide[111:56] | {55'd0, |wide[55:0]};

    // Stop the left shift at the smallest exponent so tiny sums stay subnormal.
    assign lz_all = lz56(sum_reg[55:0]);
    assign ex_m1  = ex_reg - 11'd1;

    // Normalize, then round to nearest even and pack.
    always_comb
    begin
        if (sum_reg[56])
        begin
            nrm = {sum_reg[56:2], |sum_reg[1:0]};
            exn = $signed({2'b00, ex_reg}) + 13'sd1;
        end
        else
        begin
            nrm = sum_reg[55:0] << lz_reg;
            exn = $signed({2'b00, ex_reg}) - $signed({7'd0, lz_reg});
        end
        rnd = nrm[2] && (nrm[1] || nrm[0] || nrm[3]);
        m54 = {1'b0, nrm[55:3]} + 54'(rnd);
        exr = m54[53] ? exn + 13'sd1 : exn;
        if (zero_reg)
        begin
            rounded = 64'd0;
        end
        else if (exr >= 13'sd2047)
        begin
            rounded = {sign_reg, fdpa_pkg::F64_EXP_ONES, 52'd0};
        end
        else if (m54[53])
        begin
            rounded = {sign_reg, exr[10:0], m54[52:1]};
        end
        else
        begin
            // Packs a subnormal with zero exponent unless the hidden bit is set.
            rounded = {sign_reg, m54[52] ? exr[10:0] : 11'd0, m54[51:0]};
        end
        res = spec_reg ? spec_bits_reg : rounded;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_ALIGN;
            acc_reg       <= 64'd0;
            out_valid_reg <= 1'b0;
            out_bits_reg  <= 64'd0;
        end
        else
        begin
            if (pop && out_valid_reg)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_ALIGN:
                begin
                    if (start)
                    begin
                        state_reg <= ST_ADD;
                    end
                end
                ST_ADD:
                begin
                    state_reg <= ST_NORM;
                end
                ST_NORM:
                begin
                    state_reg <= ST_ROUND;
                end
                ST_ROUND:
                begin
                    state_reg <= ST_ALIGN;
                    if (last_reg)
                    begin
                        acc_reg       <= 64'd0;
                        out_valid_reg <= 1'b1;
                        out_bits_reg  <= res;
                    end
                    else
                    begin
                        acc_reg <= res;
                    end
                end
                default:
                begin
                    state_reg <= ST_ALIGN;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            spec_reg      <= spec_next;
            spec_bits_reg <= spec_bits_next;
            last_reg      <= q_head.last;
            ml_reg        <= m_big;
            ms_reg        <= sml_sh;
            sub_reg       <= acc_reg[63] ^ h[63];
            sign_reg      <= big[63];
            ex_reg        <= e_big;
        end
        if (state_reg == ST_ADD)
        begin
            sum_reg <= sub_reg ? ({1'b0, ml_reg} - {1'b0, ms_reg})
                               : ({1'b0, ml_reg} + {1'b0, ms_reg});
        end
        if (state_reg == ST_NORM)
        begin
            lz_reg   <= ({5'd0, lz_all} < ex_m1) ? lz_all : ex_m1[5:0];
            zero_reg <= (sum_reg == 57'd0);
        end
    end

    assign empty    = !out_valid_reg;
    assign sum_bits = out_bits_reg;

endmodule

`default_nettype wire

### hw/rtl/float_dot_product_double_accum_unit.sv
// Top level of the binary32 dot product unit with binary64 accumulation.
//
//  channel   | direction | handshake          | fields
//  ----------+-----------+--------------------+------------------------------
//  pairs     | in        | push / full        | a_bits, b_bits, last_pair
//  result    | out       | empty / pop        | sum_bits
//
// Each pair goes through the accumulator's align, add, normalize and round
// steps against the running sum, which the next pair needs first.
// The front end takes a pair per cycle until the product queue fills; the last
// pair passes the front-end registers, the queue and the accumulator steps before its result is registered.
// Reset is asynchronous and clears the sum to +0.0 at once.
// A waiting result stalls only a following vector's last pair.
`default_nettype none

module float_dot_product_double_accum_unit #(
    parameter int QDEPTH = fdpa_pkg::QUEUE_DEPTH
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [31:0] a_bits,
    input  logic [31:0] b_bits,
    input  logic        last_pair,
    output logic        empty,
    input  logic        pop,
    output logic [63:0] sum_bits
);

`include "float_dot_product_double_accum_unit_macros.svh"

    localparam int CW = $clog2(QDEPTH + 1);

    // Products flow front -> queue -> back; the front counts queue space itself.
    logic            q_push;
    fdpa_pkg::prod_t q_din;
    logic            q_pop;
    fdpa_pkg::prod_t q_dout;
    logic            q_empty;
    logic [CW-1:0]   q_count;

    fdpa_front #(.QDEPTH(QDEPTH)) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .a_bits    (a_bits),
        .b_bits    (b_bits),
        .last_pair (last_pair),
        .push      (push),
        .full      (full),
        .q_count   (q_count),
        .q_push    (q_push),
        .q_data    (q_din)
    );

    fdpa_queue #(.QDEPTH(QDEPTH)) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .din   (q_din),
        .pop   (q_pop),
        .dout  (q_dout),
        .empty (q_empty),
        .count (q_count)
    );

    fdpa_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_empty  (q_empty),
        .q_head   (q_dout),
        .q_pop    (q_pop),
        .pop      (pop),
        .empty    (empty),
        .sum_bits (sum_bits)
    );

    // Credit scheme must keep every in-flight product room in the queue.
    `FDPA_ASSERT_NEVER(a_q_overrun, q_push && !q_pop && (q_count == CW'(QDEPTH)), "queue overrun")
    `FDPA_ASSERT_NEVER(a_q_underrun, q_pop && q_empty, "pop from empty queue")
    `FDPA_ASSERT_NEXT(a_q_hold, q_push, q_count != '0, "pushed product lost")

endmodule

`default_nettype wire
